// ----- sv/tvs_pkg.sv -----
// Shared constants, types and codes of the trilinear voxel sampler.
// Used by tvs_front, tvs_queue, tvs_back and trilinear_voxel_sampler_core.
package tvs_pkg;

	// Grid geometry and number formats
	localparam int AXIS_BITS  = 5;
	localparam int VALUE_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int OUT_BITS   = 16;
	localparam int SIZE_BITS  = 6;
	localparam int COORD_BITS = AXIS_BITS + FRAC_BITS;
	localparam int ADDR_BITS  = 3 * AXIS_BITS;

	// Eight parity banks, one per corner of a cell; each holds every other index per axis
	localparam int NUM_BANKS  = 8;
	localparam int HALF_BITS  = AXIS_BITS - 1;
	localparam int BANK_AW    = 3 * HALF_BITS;
	localparam int BANK_DEPTH = 1 << BANK_AW;

	localparam logic [SIZE_BITS-1:0] AXIS_LEN   = SIZE_BITS'(1 << AXIS_BITS);
	localparam logic [SIZE_BITS-1:0] SIZE_ONE   = SIZE_BITS'(1);
	localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(32);

	// Datapath widths of the three lerp passes
	localparam int DX_W = VALUE_BITS + 1;
	localparam int A_W  = VALUE_BITS + FRAC_BITS;
	localparam int PX_W = VALUE_BITS + FRAC_BITS + 2;
	localparam int DY_W = A_W + 1;
	localparam int B_W  = VALUE_BITS + 2 * FRAC_BITS;
	localparam int PY_W = A_W + FRAC_BITS + 2;
	localparam int DZ_W = B_W + 1;
	localparam int C_W  = VALUE_BITS + 3 * FRAC_BITS;
	localparam int PZ_W = B_W + FRAC_BITS + 2;
	localparam int T_W  = C_W + 1;
	localparam int R_W  = T_W - 3 * FRAC_BITS;

	localparam logic signed [T_W-1:0] ROUND_HALF = T_W'(1) <<< (3 * FRAC_BITS - 1);
	localparam logic signed [R_W-1:0] SAT_MAX    = R_W'((1 << (OUT_BITS - 1)) - 1);
	localparam logic signed [R_W-1:0] SAT_MIN    = R_W'(-(1 << (OUT_BITS - 1)));

	// Buffering
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH   = 16;
	localparam int OPTR_W      = $clog2(OUT_DEPTH);
	localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

	// Item codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SIZE_X = 2'd0,
		CFG_SIZE_Y = 2'd1,
		CFG_SIZE_Z = 2'd2
	} cfg_reg_t;

	// Decoded item handed from the front to the back; axis order is x, y, z from bit 0
	typedef struct packed {
		logic                                is_sample;
		logic [2:0]                          wbank;
		logic [BANK_AW-1:0]                  waddr;
		logic [VALUE_BITS-1:0]               wdata;
		logic [NUM_BANKS-1:0][BANK_AW-1:0]   raddr;
		logic [2:0]                          lo_par;
		logic [2:0]                          hi_par;
		logic [2:0][FRAC_BITS-1:0]           frac;
	} tvs_entry_t;

endpackage

// ----- sv/tvs_front.sv -----
// Front end: takes input transfers, holds the axis size registers, clamps the
// cell corners and works out per-bank addresses. Depends on tvs_pkg.
module tvs_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 full,
	input  logic                                 opcode,
	input  logic [tvs_pkg::ADDR_BITS-1:0]        write_addr,
	input  logic signed [tvs_pkg::VALUE_BITS-1:0] write_value,
	input  logic [tvs_pkg::COORD_BITS-1:0]       coord_x,
	input  logic [tvs_pkg::COORD_BITS-1:0]       coord_y,
	input  logic [tvs_pkg::COORD_BITS-1:0]       coord_z,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tvs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [tvs_pkg::SIZE_BITS-1:0]        cfg_data,
	output logic                                 push,
	output tvs_pkg::tvs_entry_t                  entry
);

	localparam int AXIS_BITS  = tvs_pkg::AXIS_BITS;
	localparam int FRAC_BITS  = tvs_pkg::FRAC_BITS;
	localparam int COORD_BITS = tvs_pkg::COORD_BITS;
	localparam int SIZE_BITS  = tvs_pkg::SIZE_BITS;
	localparam int HALF_BITS  = tvs_pkg::HALF_BITS;
	localparam int NUM_BANKS  = tvs_pkg::NUM_BANKS;

	logic [SIZE_BITS-1:0]  size_q [3];
	logic [COORD_BITS-1:0] crd    [3];
	logic [SIZE_BITS-1:0]  eff    [3];
	logic [SIZE_BITS-1:0]  ip1    [3];
	logic [AXIS_BITS-1:0]  ipart  [3];
	logic [AXIS_BITS-1:0]  last   [3];
	logic [AXIS_BITS-1:0]  i0     [3];
	logic [AXIS_BITS-1:0]  i1     [3];
	logic [HALF_BITS-1:0]  half   [3][2];

	assign cfg_ready = 1'b1;
	assign push      = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				size_q[k] <= tvs_pkg::SIZE_RESET;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				tvs_pkg::CFG_SIZE_X: size_q[0] <= cfg_data;
				tvs_pkg::CFG_SIZE_Y: size_q[1] <= cfg_data;
				tvs_pkg::CFG_SIZE_Z: size_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign crd[0] = coord_x;
	assign crd[1] = coord_y;
	assign crd[2] = coord_z;

	// Clamp both corners of each axis; the two corners of a cell fall in banks of
	// opposite parity unless clamping folds them onto one index.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (size_q[a] == '0) begin
				eff[a] = tvs_pkg::SIZE_ONE;
			end else if (size_q[a] > tvs_pkg::AXIS_LEN) begin
				eff[a] = tvs_pkg::AXIS_LEN;
			end else begin
				eff[a] = size_q[a];
			end
			last[a]  = AXIS_BITS'(eff[a] - tvs_pkg::SIZE_ONE);
			ipart[a] = crd[a][COORD_BITS-1:FRAC_BITS];
			ip1[a]   = SIZE_BITS'(ipart[a]) + tvs_pkg::SIZE_ONE;
			i0[a]    = (SIZE_BITS'(ipart[a]) < eff[a]) ? ipart[a] : last[a];
			i1[a]    = (ip1[a] < eff[a]) ? ip1[a][AXIS_BITS-1:0] : last[a];
			for (int p = 0; p < 2; p++) begin
				half[a][p] = (i0[a][0] == 1'(p)) ? i0[a][AXIS_BITS-1:1] : i1[a][AXIS_BITS-1:1];
			end
		end
	end

	always_comb begin
		entry.is_sample = (opcode == tvs_pkg::OP_SAMPLE);
		entry.wbank     = {write_addr[2*AXIS_BITS], write_addr[AXIS_BITS], write_addr[0]};
		entry.waddr     = {write_addr[3*AXIS_BITS-1:2*AXIS_BITS+1],
		                   write_addr[2*AXIS_BITS-1:AXIS_BITS+1],
		                   write_addr[AXIS_BITS-1:1]};
		entry.wdata     = write_value;
		for (int b = 0; b < NUM_BANKS; b++) begin
			entry.raddr[b] = {half[2][(b >> 2) & 1], half[1][(b >> 1) & 1], half[0][b & 1]};
		end
		for (int a = 0; a < 3; a++) begin
			entry.lo_par[a] = i0[a][0];
			entry.hi_par[a] = i1[a][0];
			entry.frac[a]   = crd[a][FRAC_BITS-1:0];
		end
	end

endmodule

// ----- sv/tvs_queue.sv -----
// Short queue of decoded items between the front and the back.
// Depends on tvs_pkg for the entry type and depth.
module tvs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tvs_pkg::tvs_entry_t entry_in,
	output logic                full,
	input  logic                pop,
	output logic                valid,
	output tvs_pkg::tvs_entry_t head
);

	localparam int QUEUE_DEPTH = tvs_pkg::QUEUE_DEPTH;
	localparam int QPTR_W      = tvs_pkg::QPTR_W;
	localparam int QCNT_W      = tvs_pkg::QCNT_W;

	tvs_pkg::tvs_entry_t ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/tvs_back.sv -----
// Back end: eight parity-banked voxel memories, corner select, the x, y and z
// lerp pipeline, rounding and the result buffer. Depends on tvs_pkg.
module tvs_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	input  tvs_pkg::tvs_entry_t                  head,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [tvs_pkg::OUT_BITS-1:0]  sample_value
);

	localparam int VALUE_BITS = tvs_pkg::VALUE_BITS;
	localparam int FRAC_BITS  = tvs_pkg::FRAC_BITS;
	localparam int OUT_BITS   = tvs_pkg::OUT_BITS;
	localparam int NUM_BANKS  = tvs_pkg::NUM_BANKS;
	localparam int BANK_DEPTH = tvs_pkg::BANK_DEPTH;
	localparam int DX_W = tvs_pkg::DX_W;
	localparam int A_W  = tvs_pkg::A_W;
	localparam int PX_W = tvs_pkg::PX_W;
	localparam int DY_W = tvs_pkg::DY_W;
	localparam int B_W  = tvs_pkg::B_W;
	localparam int PY_W = tvs_pkg::PY_W;
	localparam int DZ_W = tvs_pkg::DZ_W;
	localparam int C_W  = tvs_pkg::C_W;
	localparam int PZ_W = tvs_pkg::PZ_W;
	localparam int T_W  = tvs_pkg::T_W;
	localparam int R_W  = tvs_pkg::R_W;
	localparam int OUT_DEPTH = tvs_pkg::OUT_DEPTH;
	localparam int OPTR_W    = tvs_pkg::OPTR_W;
	localparam int OCNT_W    = tvs_pkg::OCNT_W;

	logic                          pop_sample;
	logic                          rd_en;
	logic                          out_acc;
	logic [OCNT_W-1:0]             resv_q;

	logic signed [VALUE_BITS-1:0]  bank_rd [NUM_BANKS];

	logic                          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [2:0]                    lo_par_s1, hi_par_s1;
	logic [2:0][FRAC_BITS-1:0]     frac_s1;

	logic signed [VALUE_BITS-1:0]  clo [4];
	logic signed [VALUE_BITS-1:0]  chi [4];
	logic signed [VALUE_BITS-1:0]  xlo_s2 [4];
	logic signed [DX_W-1:0]        dx_s2  [4];
	logic [FRAC_BITS-1:0]          fx_s2, fy_s2, fz_s2;

	logic signed [PX_W-1:0]        px     [4];
	logic signed [A_W-1:0]         a_next [4];
	logic signed [A_W-1:0]         a_s3   [4];
	logic [FRAC_BITS-1:0]          fy_s3, fz_s3;

	logic signed [A_W-1:0]         ylo_s4 [2];
	logic signed [DY_W-1:0]        dy_s4  [2];
	logic [FRAC_BITS-1:0]          fy_s4, fz_s4;

	logic signed [PY_W-1:0]        py     [2];
	logic signed [B_W-1:0]         b_next [2];
	logic signed [B_W-1:0]         b_s5   [2];
	logic [FRAC_BITS-1:0]          fz_s5;

	logic signed [B_W-1:0]         zlo_s6;
	logic signed [DZ_W-1:0]        dz_s6;
	logic [FRAC_BITS-1:0]          fz_s6;

	logic signed [PZ_W-1:0]        pz;
	logic signed [C_W-1:0]         c_next;
	logic signed [C_W-1:0]         c_s7;

	logic signed [T_W-1:0]         rnd_t;
	logic signed [R_W-1:0]         rnd_r;
	logic signed [OUT_BITS-1:0]    sat_val;

	logic signed [OUT_BITS-1:0]    ofifo_q [OUT_DEPTH];
	logic [OPTR_W-1:0]             wptr_q, rptr_q;
	logic [OCNT_W-1:0]             ocnt_q;

	// A sample leaves the queue only when the result buffer has a place reserved for it
	assign q_pop      = q_valid && (!head.is_sample || (resv_q < OCNT_W'(OUT_DEPTH)));
	assign pop_sample = q_pop && head.is_sample;
	assign rd_en      = pop_sample;
	assign out_valid  = (ocnt_q != '0);
	assign out_acc    = out_valid && !out_stall;
	assign sample_value = ofifo_q[rptr_q];

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic [VALUE_BITS-1:0] mem [BANK_DEPTH];
		logic [VALUE_BITS-1:0] rdata_s1;
		logic                  wr_en;

		assign wr_en = q_pop && !head.is_sample && (head.wbank == 3'(b));

		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[head.waddr] <= head.wdata;
			end
			if (rd_en) begin
				rdata_s1 <= mem[head.raddr[b]];
			end
		end

		assign bank_rd[b] = $signed(rdata_s1);
	end

	// Pick each corner from the bank that holds its parity; j bit 0 is the y corner,
	// bit 1 the z corner.
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			clo[j] = bank_rd[{((j & 2) != 0) ? hi_par_s1[2] : lo_par_s1[2],
			                  ((j & 1) != 0) ? hi_par_s1[1] : lo_par_s1[1],
			                  lo_par_s1[0]}];
			chi[j] = bank_rd[{((j & 2) != 0) ? hi_par_s1[2] : lo_par_s1[2],
			                  ((j & 1) != 0) ? hi_par_s1[1] : lo_par_s1[1],
			                  hi_par_s1[0]}];
		end
	end

	// Each lerp: lo scaled by the fraction range plus fraction times the difference
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			px[j]     = PX_W'($signed({1'b0, fx_s2})) * PX_W'(dx_s2[j]);
			a_next[j] = A_W'((PX_W'(xlo_s2[j]) <<< FRAC_BITS) + px[j]);
		end
		for (int k = 0; k < 2; k++) begin
			py[k]     = PY_W'($signed({1'b0, fy_s4})) * PY_W'(dy_s4[k]);
			b_next[k] = B_W'((PY_W'(ylo_s4[k]) <<< FRAC_BITS) + py[k]);
		end
		pz     = PZ_W'($signed({1'b0, fz_s6})) * PZ_W'(dz_s6);
		c_next = C_W'((PZ_W'(zlo_s6) <<< FRAC_BITS) + pz);
	end

	// Round half up, then saturate to the output range
	always_comb begin
		rnd_t = T_W'(c_s7) + tvs_pkg::ROUND_HALF;
		rnd_r = rnd_t[T_W-1:3*FRAC_BITS];
		if (rnd_r > tvs_pkg::SAT_MAX) begin
			sat_val = OUT_BITS'(tvs_pkg::SAT_MAX);
		end else if (rnd_r < tvs_pkg::SAT_MIN) begin
			sat_val = OUT_BITS'(tvs_pkg::SAT_MIN);
		end else begin
			sat_val = OUT_BITS'(rnd_r);
		end
	end

	always_ff @(posedge clk) begin
		lo_par_s1 <= head.lo_par;
		hi_par_s1 <= head.hi_par;
		frac_s1   <= head.frac;

		for (int j = 0; j < 4; j++) begin
			xlo_s2[j] <= clo[j];
			dx_s2[j]  <= DX_W'(chi[j]) - DX_W'(clo[j]);
		end
		fx_s2 <= frac_s1[0];
		fy_s2 <= frac_s1[1];
		fz_s2 <= frac_s1[2];

		for (int j = 0; j < 4; j++) begin
			a_s3[j] <= a_next[j];
		end
		fy_s3 <= fy_s2;
		fz_s3 <= fz_s2;

		for (int k = 0; k < 2; k++) begin
			ylo_s4[k] <= a_s3[2*k];
			dy_s4[k]  <= DY_W'(a_s3[2*k+1]) - DY_W'(a_s3[2*k]);
		end
		fy_s4 <= fy_s3;
		fz_s4 <= fz_s3;

		for (int k = 0; k < 2; k++) begin
			b_s5[k] <= b_next[k];
		end
		fz_s5 <= fz_s4;

		zlo_s6 <= b_s5[0];
		dz_s6  <= DZ_W'(b_s5[1]) - DZ_W'(b_s5[0]);
		fz_s6  <= fz_s5;

		c_s7 <= c_next;

		if (v_s7) begin
			ofifo_q[wptr_q] <= sat_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			wptr_q <= '0;
			rptr_q <= '0;
			ocnt_q <= '0;
			resv_q <= '0;
		end else begin
			v_s1 <= pop_sample;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			if (v_s7) begin
				wptr_q <= wptr_q + OPTR_W'(1);
			end
			if (out_acc) begin
				rptr_q <= rptr_q + OPTR_W'(1);
			end
			case ({v_s7, out_acc})
				2'b10:   ocnt_q <= ocnt_q + OCNT_W'(1);
				2'b01:   ocnt_q <= ocnt_q - OCNT_W'(1);
				default: ocnt_q <= ocnt_q;
			endcase
			// Hold a reservation from pop until the result transfer
			case ({pop_sample, out_acc})
				2'b10:   resv_q <= resv_q + OCNT_W'(1);
				2'b01:   resv_q <= resv_q - OCNT_W'(1);
				default: resv_q <= resv_q;
			endcase
		end
	end

endmodule

// ----- sv/trilinear_voxel_sampler_core.sv -----
// Throughput: one item (voxel write or sample) per cycle while in_stall is low, set by
// the eight parity banks that deliver all corners of a cell in one read.
// A sample's result passes the queue, bank read, corner select, three lerp passes of
// two stages each and the result buffer before it can be transferred.
// Up to 16 results are buffered while the output is stalled.
// Reset clears control state and sets all axis sizes to 32; voxel memory is not cleared.
module trilinear_voxel_sampler_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic [tvs_pkg::ADDR_BITS-1:0]        write_addr,
	input  logic signed [tvs_pkg::VALUE_BITS-1:0] write_value,
	input  logic [tvs_pkg::COORD_BITS-1:0]       coord_x,
	input  logic [tvs_pkg::COORD_BITS-1:0]       coord_y,
	input  logic [tvs_pkg::COORD_BITS-1:0]       coord_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [tvs_pkg::OUT_BITS-1:0]  sample_value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tvs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [tvs_pkg::SIZE_BITS-1:0]        cfg_data
);

	logic                q_full;
	logic                q_push;
	logic                q_pop;
	logic                q_valid;
	tvs_pkg::tvs_entry_t fe_entry;
	tvs_pkg::tvs_entry_t q_head;

	assign in_stall = q_full;

	tvs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.full        (q_full),
		.opcode      (opcode),
		.write_addr  (write_addr),
		.write_value (write_value),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (q_push),
		.entry       (fe_entry)
	);

	tvs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.entry_in (fe_entry),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	tvs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.head         (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_value (sample_value)
	);

endmodule

// ----- sim/tvs_sample_checker.sv -----
// Scoreboard for trilinear_voxel_sampler_core: mirrors the voxel grid and axis sizes
// from observed transfers and checks every sample result in arrival order.
// Depends on tvs_pkg only.
module tvs_sample_checker
	import tvs_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         opcode,
	input  logic [ADDR_BITS-1:0]         write_addr,
	input  logic signed [VALUE_BITS-1:0] write_value,
	input  logic [COORD_BITS-1:0]        coord_x,
	input  logic [COORD_BITS-1:0]        coord_y,
	input  logic [COORD_BITS-1:0]        coord_z,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [OUT_BITS-1:0]   sample_value,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [SIZE_BITS-1:0]         cfg_data,
	output int                           mismatches,
	output int                           pending,
	output int                           checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [OUT_BITS-1:0] value;
		logic [COORD_BITS-1:0]      cx;
		logic [COORD_BITS-1:0]      cy;
		logic [COORD_BITS-1:0]      cz;
	} sample_expect_t;

	sample_expect_t expected_samples[$];
	logic signed [VALUE_BITS-1:0] grid [0:(1 << ADDR_BITS) - 1];
	logic [SIZE_BITS-1:0] span_x = SIZE_RESET;
	logic [SIZE_BITS-1:0] span_y = SIZE_RESET;
	logic [SIZE_BITS-1:0] span_z = SIZE_RESET;

	// Zero acts as one, anything past the axis length saturates
	function automatic int unsigned axis_span(logic [SIZE_BITS-1:0] s);
		if (s == '0)
			return 1;
		if (s > AXIS_LEN)
			return int'(AXIS_LEN);
		return int'(s);
	endfunction

	function automatic int unsigned corner_index(int unsigned i, logic [SIZE_BITS-1:0] s);
		int unsigned lim;
		lim = axis_span(s);
		return (i < lim) ? i : lim - 1;
	endfunction

	function automatic longint voxel_at(int unsigned x, int unsigned y, int unsigned z);
		return longint'(grid[{z[AXIS_BITS-1:0], y[AXIS_BITS-1:0], x[AXIS_BITS-1:0]}]);
	endfunction

	// Exact lerp: result carries FRAC_BITS more fraction bits than its inputs
	function automatic longint lerp_step(longint lo, longint hi, longint f);
		return lo * (longint'(1) << FRAC_BITS) + f * (hi - lo);
	endfunction

	function automatic logic signed [OUT_BITS-1:0] predict_sample(
			logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy, logic [COORD_BITS-1:0] cz);
		int unsigned ix, iy, iz, x0, x1, y0, y1, z0, z1;
		longint fx, fy, fz, a00, a10, a01, a11, b0, b1, c, r, top;
		ix = 32'(cx[COORD_BITS-1:FRAC_BITS]);
		iy = 32'(cy[COORD_BITS-1:FRAC_BITS]);
		iz = 32'(cz[COORD_BITS-1:FRAC_BITS]);
		fx = longint'(cx[FRAC_BITS-1:0]);
		fy = longint'(cy[FRAC_BITS-1:0]);
		fz = longint'(cz[FRAC_BITS-1:0]);
		x0 = corner_index(ix, span_x);
		x1 = corner_index(ix + 1, span_x);
		y0 = corner_index(iy, span_y);
		y1 = corner_index(iy + 1, span_y);
		z0 = corner_index(iz, span_z);
		z1 = corner_index(iz + 1, span_z);
		a00 = lerp_step(voxel_at(x0, y0, z0), voxel_at(x1, y0, z0), fx);
		a10 = lerp_step(voxel_at(x0, y1, z0), voxel_at(x1, y1, z0), fx);
		a01 = lerp_step(voxel_at(x0, y0, z1), voxel_at(x1, y0, z1), fx);
		a11 = lerp_step(voxel_at(x0, y1, z1), voxel_at(x1, y1, z1), fx);
		b0 = lerp_step(a00, a10, fy);
		b1 = lerp_step(a01, a11, fy);
		c = lerp_step(b0, b1, fz);
		// Arithmetic shift floors, so adding half rounds ties upwards
		r = (c + (longint'(1) << (3 * FRAC_BITS - 1))) >>> (3 * FRAC_BITS);
		top = (longint'(1) << (OUT_BITS - 1)) - 1;
		if (r > top)
			r = top;
		if (r < -top - 1)
			r = -top - 1;
		return OUT_BITS'(r);
	endfunction

	always @(posedge clk) begin : watch
		sample_expect_t e;
		if (!arst_n) begin
			span_x = SIZE_RESET;
			span_y = SIZE_RESET;
			span_z = SIZE_RESET;
			expected_samples.delete();
			mismatches = 0;
			checked = 0;
		end else begin
			// Compare first: a result never belongs to an item accepted at the same edge
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: sample_value %0d arrived with no sample outstanding",
							$realtime, sample_value);
				end else begin
					e = expected_samples.pop_front();
					checked++;
					if (sample_value !== e.value) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t: sample (%h,%h,%h) expected %0d got %0d",
								$realtime, e.cx, e.cy, e.cz, e.value, sample_value);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SIZE_X: span_x = cfg_data;
					CFG_SIZE_Y: span_y = cfg_data;
					CFG_SIZE_Z: span_z = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (opcode == OP_WRITE) begin
					grid[write_addr] = write_value;
				end else begin
					e.value = predict_sample(coord_x, coord_y, coord_z);
					e.cx = coord_x;
					e.cy = coord_y;
					e.cz = coord_z;
					expected_samples.push_back(e);
				end
			end
		end
		pending = expected_samples.size();
	end

endmodule

// ----- sim/trilinear_voxel_sampler_core_tb.sv -----
// Top of the trilinear voxel sampler testbench: clock, reset, stimulus and verdict.
// Depends on tvs_pkg, trilinear_voxel_sampler_core and tvs_sample_checker.
module trilinear_voxel_sampler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tvs_pkg::*;

	localparam int ITEM_TARGET  = 1950;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 24;
	localparam int IDLE_PCT     = 7;
	localparam int PHASE_ITEMS  = 150;
	localparam int REGION_MAX   = 64;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;
	localparam logic [VALUE_BITS-1:0]   VOXEL_MAX = 16'h7FFF;
	localparam logic [VALUE_BITS-1:0]   VOXEL_MIN = 16'h8000;
	localparam logic [COORD_BITS-1:0]   COORD_TOP  = '1;
	localparam logic [COORD_BITS-1:0]   COORD_HALF = 13'd128;
	localparam logic [COORD_BITS-1:0]   COORD_ONE  = 13'd256;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         opcode = OP_WRITE;
	logic [ADDR_BITS-1:0]         write_addr = '0;
	logic signed [VALUE_BITS-1:0] write_value = '0;
	logic [COORD_BITS-1:0]        coord_x = '0;
	logic [COORD_BITS-1:0]        coord_y = '0;
	logic [COORD_BITS-1:0]        coord_z = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [OUT_BITS-1:0]   sample_value;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
	logic [SIZE_BITS-1:0]         cfg_data = '0;

	int mismatches;
	int pending;
	int checked;
	bit quiet = 1'b0;
	int items_sent = 0;
	int samples_sent = 0;
	int writes_sent = 0;
	int settings_used = 0;
	int cycle_count = 0;

	trilinear_voxel_sampler_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .write_addr(write_addr), .write_value(write_value),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_stall(out_stall), .sample_value(sample_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tvs_sample_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .write_addr(write_addr), .write_value(write_value),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_stall(out_stall), .sample_value(sample_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending), .checked(checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("trilinear_voxel_sampler_core_tb NOT OK");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);

	function automatic int unsigned span_of(logic [SIZE_BITS-1:0] s);
		if (s == '0)
			return 1;
		return (s > AXIS_LEN) ? int'(AXIS_LEN) : int'(s);
	endfunction

	// Vary the encoding: a span of one may be written as zero, a full axis as 33..63
	function automatic logic [SIZE_BITS-1:0] encode_span(int unsigned n);
		if (n == 1 && $urandom_range(0, 2) == 0)
			return '0;
		if (n == 32 && $urandom_range(0, 1) == 0)
			return SIZE_BITS'($urandom_range(33, 63));
		return SIZE_BITS'(n);
	endfunction

	function automatic logic [ADDR_BITS-1:0] voxel_addr(int unsigned x, int unsigned y,
			int unsigned z);
		return {AXIS_BITS'(z), AXIS_BITS'(y), AXIS_BITS'(x)};
	endfunction

	function automatic logic [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return VOXEL_MAX;
			1: return VOXEL_MIN;
			2: return '0;
			3: return '1;
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	// Mostly inside the used cell range; some anywhere so the corner clamp gets hit
	function automatic logic [COORD_BITS-1:0] pick_coord(int unsigned lim);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return COORD_BITS'($urandom);
		if (r < 22)
			return {AXIS_BITS'(lim - 1), FRAC_BITS'($urandom)};
		return {AXIS_BITS'($urandom_range(0, lim - 1)), FRAC_BITS'($urandom)};
	endfunction

	// Called just after a falling edge; returns just after the falling edge that follows
	// the transfer
	task automatic send_item(input logic op, input logic [ADDR_BITS-1:0] addr,
			input logic [VALUE_BITS-1:0] value, input logic [COORD_BITS-1:0] cx,
			input logic [COORD_BITS-1:0] cy, input logic [COORD_BITS-1:0] cz);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		write_addr <= addr;
		write_value <= value;
		coord_x <= cx;
		coord_y <= cy;
		coord_z <= cz;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		items_sent++;
		if (op == OP_SAMPLE)
			samples_sent++;
		else
			writes_sent++;
	endtask

	task automatic send_write(input logic [ADDR_BITS-1:0] addr,
			input logic [VALUE_BITS-1:0] value);
		send_item(OP_WRITE, addr, value, COORD_BITS'($urandom), COORD_BITS'($urandom),
			COORD_BITS'($urandom));
	endtask

	task automatic send_sample(input logic [COORD_BITS-1:0] cx,
			input logic [COORD_BITS-1:0] cy, input logic [COORD_BITS-1:0] cz);
		send_item(OP_SAMPLE, ADDR_BITS'($urandom), VALUE_BITS'($urandom), cx, cy, cz);
	endtask

	// Hold cfg_valid high across a group of writes; the caller drops it at the end
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [SIZE_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	// Drain everything in flight before touching the size registers
	task automatic set_spans(input logic [SIZE_BITS-1:0] sx, input logic [SIZE_BITS-1:0] sy,
			input logic [SIZE_BITS-1:0] sz, input bit spare);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		write_reg(CFG_SIZE_X, sx);
		write_reg(CFG_SIZE_Y, sy);
		write_reg(CFG_SIZE_Z, sz);
		if (spare)
			write_reg(CFG_IDX_SPARE, SIZE_BITS'($urandom));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic random_item(input int unsigned ex, input int unsigned ey,
			input int unsigned ez);
		logic [ADDR_BITS-1:0] addr;
		if ($urandom_range(0, 99) < 30) begin
			if ($urandom_range(0, 4) == 0)
				addr = ADDR_BITS'($urandom);
			else
				addr = voxel_addr($urandom_range(0, ex - 1), $urandom_range(0, ey - 1),
					$urandom_range(0, ez - 1));
			send_write(addr, pick_value());
		end else begin
			send_sample(pick_coord(ex), pick_coord(ey), pick_coord(ez));
		end
	endtask

	// Fill every voxel that the spans can reach, then mix writes and samples
	task automatic run_phase(input logic [SIZE_BITS-1:0] sx, input logic [SIZE_BITS-1:0] sy,
			input logic [SIZE_BITS-1:0] sz, input bit spare);
		int unsigned ex, ey, ez;
		set_spans(sx, sy, sz, spare);
		ex = span_of(sx);
		ey = span_of(sy);
		ez = span_of(sz);
		for (int unsigned z = 0; z < ez; z++)
			for (int unsigned y = 0; y < ey; y++)
				for (int unsigned x = 0; x < ex; x++)
					send_write(voxel_addr(x, y, z), pick_value());
		repeat (PHASE_ITEMS) random_item(ex, ey, ez);
	endtask

	initial begin : stimulus
		int unsigned nx, ny, nz;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: 2x2x2 grid with extreme values and rounding ties of both signs
		set_spans(SIZE_BITS'(2), SIZE_BITS'(2), SIZE_BITS'(2), 1'b0);
		send_write(voxel_addr(0, 0, 0), VOXEL_MAX);
		send_write(voxel_addr(1, 0, 0), VOXEL_MIN);
		send_write(voxel_addr(0, 1, 0), VALUE_BITS'(0));
		send_write(voxel_addr(1, 1, 0), VALUE_BITS'(1));
		send_write(voxel_addr(0, 0, 1), '1);
		send_write(voxel_addr(1, 0, 1), VALUE_BITS'(0));
		send_write(voxel_addr(0, 1, 1), VOXEL_MIN);
		send_write(voxel_addr(1, 1, 1), VOXEL_MAX);
		send_sample('0, '0, '0);
		send_sample(COORD_TOP, COORD_TOP, COORD_TOP);
		send_sample(COORD_HALF, '0, '0);
		send_sample(COORD_HALF, COORD_ONE, '0);
		send_sample(COORD_HALF, '0, COORD_ONE);
		send_sample(COORD_HALF, COORD_HALF, COORD_HALF);
		send_sample(13'd255, 13'd255, 13'd255);
		send_sample(COORD_ONE, '0, '0);
		send_sample('0, 13'd255, '0);
		// Read straight after write to catch a stale bank read
		send_write(voxel_addr(0, 0, 0), VOXEL_MIN);
		send_sample('0, '0, '0);
		send_write(voxel_addr(1, 1, 1), VALUE_BITS'(0));
		send_sample(COORD_TOP, COORD_TOP, COORD_TOP);
		send_write(voxel_addr(1, 0, 0), VALUE_BITS'(12345));
		send_sample(13'd64, '0, '0);

		run_phase(SIZE_BITS'(32), SIZE_BITS'(1), SIZE_BITS'(1), 1'b0);
		run_phase(SIZE_BITS'(1), SIZE_BITS'(32), SIZE_BITS'(1), 1'b0);
		run_phase(SIZE_BITS'(1), SIZE_BITS'(1), SIZE_BITS'(32), 1'b0);
		run_phase(SIZE_BITS'(0), SIZE_BITS'(63), SIZE_BITS'(0), 1'b1);
		run_phase(SIZE_BITS'(63), SIZE_BITS'(2), SIZE_BITS'(0), 1'b0);
		quiet = 1'b1;
		run_phase(SIZE_BITS'(5), SIZE_BITS'(3), SIZE_BITS'(4), 1'b0);
		quiet = 1'b0;

		while (items_sent < ITEM_TARGET) begin
			nx = $urandom_range(1, 32);
			ny = $urandom_range(1, (REGION_MAX / nx > 32) ? 32 : REGION_MAX / nx);
			nz = $urandom_range(1, (REGION_MAX / (nx * ny) > 1) ? REGION_MAX / (nx * ny) : 1);
			run_phase(encode_span(nx), encode_span(ny), encode_span(nz), 1'b0);
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("stimulus: %0d items (%0d samples, %0d voxel writes) over %0d size settings",
			items_sent, samples_sent, writes_sent, settings_used);
		$display("results compared: %0d, mismatches: %0d", checked, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("trilinear_voxel_sampler_core_tb OK");
		else
			$display("trilinear_voxel_sampler_core_tb NOT OK");
		$finish;
	end

endmodule
